[rtl/ddt_pkg.sv]
// Package: item types, register indexes and reset constants of the duty and tachometer block.
package ddt_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned NUM_KEYS   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_RELOAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DUTY    = 2'd1;

    localparam logic [7:0] DEBOUNCE_RELOAD_RST = 8'd10;
    localparam logic [7:0] INITIAL_DUTY_RST    = 8'd1;

    typedef struct packed {
        logic key_up_pin;
        logic key_down_pin;
        logic sensor_pin;
        logic debounce_tick;
        logic second_tick;
    } t_in_item;

    typedef struct packed {
        logic [7:0] duty;
        logic [7:0] speed;
    } t_result;

endpackage

[rtl/ddt_in_if.sv]
// Interface: input item channel (pin sample and tick strobes).
interface ddt_in_if;
    logic             valid;
    logic             ready;
    ddt_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/ddt_out_if.sv]
// Interface: result item channel (duty and speed).
interface ddt_out_if;
    logic             valid;
    logic             ready;
    ddt_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/debounced_duty_and_tachometer.sv]
// Top level: key debouncers, duty up/down counter and falling-edge tachometer.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+----------------------------------------------
//  i_in     | in  | valid/ready       | key_up_pin key_down_pin sensor_pin
//           |     |                   | debounce_tick second_tick
//  o_out    | out | valid/ready       | duty[7:0] speed[7:0]
//  cfg      | in  | i_cfg_we (no ack) | i_cfg_idx[1:0] i_cfg_wdata[7:0]
//
// One item per cycle while i_in.ready is high: the state update is one pass of logic ahead
// of the accepting edge, and the result is loaded into the output register at that edge
// and offered the next cycle. While o_out is stalled, a skid register takes that result
// instead and holds it; i_in.ready drops only while the skid register is full.
// Synchronous active-low reset: counters, flags and output valid clear, sensor history
// sets, duty loads its reset value 1, reload returns to 10.
module debounced_duty_and_tachometer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ddt_in_if.sink                              i_in,
    ddt_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [ddt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ddt_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    logic [7:0] r_reload;

    logic [7:0] r_key_cnt    [ddt_pkg::NUM_KEYS];
    logic       r_key_samp   [ddt_pkg::NUM_KEYS];
    logic       r_key_stab   [ddt_pkg::NUM_KEYS];
    logic       r_key_prev   [ddt_pkg::NUM_KEYS];
    logic [7:0] r_duty;
    logic       r_sensor_prev;
    logic [7:0] r_pulse;
    logic [7:0] r_speed;

    logic [7:0] n_key_cnt    [ddt_pkg::NUM_KEYS];
    logic       n_key_samp   [ddt_pkg::NUM_KEYS];
    logic       n_key_stab   [ddt_pkg::NUM_KEYS];
    logic [7:0] n_duty;
    logic [7:0] n_pulse;
    logic [7:0] n_speed;

    logic             r_out_valid;
    ddt_pkg::t_result r_out;
    logic             r_skid_valid;
    ddt_pkg::t_result r_skid;

    logic             accept;
    logic             out_free;
    logic             pin   [ddt_pkg::NUM_KEYS];
    logic [7:0]       dec   [ddt_pkg::NUM_KEYS];
    logic [7:0]       pulse_base;
    ddt_pkg::t_result result;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = !r_skid_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign pin[0] = i_in.data.key_up_pin;
    assign pin[1] = i_in.data.key_down_pin;

    always_comb begin
        for (int k = 0; k < ddt_pkg::NUM_KEYS; k++) begin
            dec[k]        = r_key_cnt[k] - 8'd1;
            n_key_cnt[k]  = r_key_cnt[k];
            n_key_samp[k] = r_key_samp[k];
            n_key_stab[k] = r_key_stab[k];
            if (i_in.data.debounce_tick) begin
                if (r_key_cnt[k] == 8'd0) begin
                    n_key_cnt[k]  = r_reload;
                    n_key_samp[k] = pin[k];
                end else if (r_key_samp[k] != pin[k]) begin
                    n_key_cnt[k]  = r_reload;
                    n_key_samp[k] = pin[k];
                end else begin
                    n_key_cnt[k] = dec[k];
                    if (dec[k] == 8'd0) begin
                        n_key_stab[k] = pin[k];
                    end
                end
            end
        end

        n_duty = r_duty;
        if (r_key_prev[0] && !n_key_stab[0]) begin
            n_duty = n_duty + 8'd1;
        end
        if (r_key_prev[1] && !n_key_stab[1]) begin
            n_duty = n_duty - 8'd1;
        end

        n_speed    = i_in.data.second_tick ? r_pulse : r_speed;
        pulse_base = i_in.data.second_tick ? 8'd0 : r_pulse;
        n_pulse    = (r_sensor_prev && !i_in.data.sensor_pin) ? pulse_base + 8'd1
                                                              : pulse_base;

        result.duty  = n_duty;
        result.speed = n_speed;
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload      <= ddt_pkg::DEBOUNCE_RELOAD_RST;
            r_duty        <= ddt_pkg::INITIAL_DUTY_RST;
            r_sensor_prev <= 1'b1;
            r_pulse       <= 8'd0;
            r_speed       <= 8'd0;
            for (int k = 0; k < ddt_pkg::NUM_KEYS; k++) begin
                r_key_cnt[k]  <= 8'd0;
                r_key_samp[k] <= 1'b0;
                r_key_stab[k] <= 1'b0;
                r_key_prev[k] <= 1'b0;
            end
        end else begin
            if (accept) begin
                for (int k = 0; k < ddt_pkg::NUM_KEYS; k++) begin
                    r_key_cnt[k]  <= n_key_cnt[k];
                    r_key_samp[k] <= n_key_samp[k];
                    r_key_stab[k] <= n_key_stab[k];
                    r_key_prev[k] <= n_key_stab[k];
                end
                r_duty        <= n_duty;
                r_sensor_prev <= i_in.data.sensor_pin;
                r_pulse       <= n_pulse;
                r_speed       <= n_speed;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ddt_pkg::REG_DEBOUNCE_RELOAD: r_reload <= i_cfg_wdata;
                    ddt_pkg::REG_INITIAL_DUTY: begin
                        r_duty <= i_cfg_wdata;
                    end
                    default: ;
                endcase
            end
        end
    end

    // output register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= accept;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : result;
        end
        if (!out_free && accept) begin
            r_skid <= result;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_valid && !o_out.ready) |=> r_skid_valid)
        else $error("item accepted under stall not held in skid register");

    a_skid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !o_out.ready) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid item lost while output stalled");

    a_duty_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!accept && !i_cfg_we) |=> $stable(r_duty))
        else $error("duty changed without an item or preset write");

endmodule
